[sv/char_lcd_i2c_expander_sequencer_core_macros.svh]
// assertion macros for the character lcd expander sequencer
// no dependencies; included by lcdx_back, the module that carries assertions
`ifndef CHAR_LCD_I2C_EXPANDER_SEQUENCER_CORE_MACROS_SVH
`define CHAR_LCD_I2C_EXPANDER_SEQUENCER_CORE_MACROS_SVH

// same-cycle implication, disabled while in reset
`define LCDX_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lcdx assertion failed");

// next-cycle implication, disabled while in reset
`define LCDX_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lcdx assertion failed");

`endif

[sv/lcdx_pkg.sv]
// shared types, codes and tables for the character lcd expander sequencer
// no dependencies
`default_nettype none

package lcdx_pkg;

  // request function codes
  localparam logic [2:0] FUNC_DATA   = 3'd0;
  localparam logic [2:0] FUNC_CMD    = 3'd1;
  localparam logic [2:0] FUNC_CURSOR = 3'd2;
  localparam logic [2:0] FUNC_CLEAR  = 3'd3;
  localparam logic [2:0] FUNC_HOME   = 3'd4;
  localparam logic [2:0] FUNC_ENTRY  = 3'd5;
  localparam logic [2:0] FUNC_INIT   = 3'd6;

  // configuration register indexes
  localparam logic CFG_BACKLIGHT = 1'b0;
  localparam logic CFG_SETTLE    = 1'b1;

  localparam int CFG_DATA_W = 10;
  localparam int QUEUE_DEPTH_DEF = 4;

  // hd44780 command bytes
  localparam logic [7:0] LCD_CLEAR      = 8'h01;
  localparam logic [7:0] LCD_HOME       = 8'h02;
  localparam logic [7:0] LCD_ENTRY      = 8'h06;
  localparam logic [7:0] LCD_SET_DDRAM  = 8'h80;
  localparam logic [7:0] LCD_FUNC_4BIT  = 8'h28;
  localparam logic [7:0] LCD_DISPLAY_ON = 8'h0C;

  localparam logic [12:0] INIT_PAUSE_US   = 13'd1000;
  localparam logic [12:0] POWER_UP_EXTRA  = 13'd4500;
  localparam logic [9:0]  SETTLE_RESET_US = 10'd50;

  // last step index of a run
  localparam logic [4:0] LAST_STEP_BYTE = 5'd3;
  localparam logic [4:0] LAST_STEP_INIT = 5'd28;
  // first step of the command part of the init run
  localparam logic [4:0] INIT_CMD_FIRST = 5'd9;
  localparam logic [4:0] INIT_NIB_LAST  = 5'd8;

  typedef struct packed {
    logic [2:0] func;
    logic [7:0] value;
    logic [4:0] column;
    logic [1:0] line_index;
    logic       shift_on;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  expander_byte;
    logic [12:0] wait_us;
    logic        last;
  } out_item_t;

  // classified request handed from front to back
  typedef struct packed {
    logic       is_init;
    logic       rs;
    logic [7:0] cmd;
  } job_t;

  function automatic logic [7:0] row_base(input logic [1:0] row);
    case (row)
      2'd0:    row_base = 8'h00;
      2'd1:    row_base = 8'h40;
      2'd2:    row_base = 8'h14;
      2'd3:    row_base = 8'h54;
      default: row_base = 8'h00;
    endcase
  endfunction

  // command bytes sent after the nibble-mode handshake of init
  function automatic logic [7:0] init_cmd(input logic [2:0] k);
    case (k)
      3'd0:    init_cmd = LCD_FUNC_4BIT;
      3'd1:    init_cmd = LCD_DISPLAY_ON;
      3'd2:    init_cmd = LCD_CLEAR;
      3'd3:    init_cmd = LCD_ENTRY;
      3'd4:    init_cmd = LCD_HOME;
      default: init_cmd = 8'h00;
    endcase
  endfunction

endpackage

`default_nettype wire

[sv/char_lcd_i2c_expander_sequencer_core.sv]
// top level of the character lcd expander sequencer: front, queue and back
// depends on lcdx_pkg, lcdx_front, lcdx_queue and lcdx_back
//
// usage:
//   a request (in_item) is taken at a clock edge where start is high and busy
//   is low. busy is high only while the job queue is full.
//   each request expands into a run of expander bytes on out_item, one byte
//   per cycle, each marked by out_strobe for one cycle; the last byte of a run
//   has last set. the receiver cannot stall; every strobed byte is final.
//   data, command, cursor, clear, home and entry requests give 4 bytes, init
//   gives 29 bytes, function code 7 gives none.
//   a request passes the queue, the back end's job register and its output
//   register before its first byte appears.
//   the back end's step counter sets the pace of one byte per cycle; runs
//   follow each other with no gap when the next request is already queued.
//   the queue holds QUEUE_DEPTH requests waiting behind the current run.
//   configuration: cfg_we writes cfg_wdata into register cfg_index (0
//   backlight, 1 settle wait in us); write only while idle.
//   reset (rst_n low, synchronous): queue and run cleared, backlight on,
//   settle wait 50 us.
`default_nettype none

module char_lcd_i2c_expander_sequencer_core #(
  parameter int QUEUE_DEPTH = lcdx_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  lcdx_pkg::in_item_t              in_item,
  output logic                            out_strobe,
  output lcdx_pkg::out_item_t             out_item,
  input  logic                            cfg_we,
  input  logic                            cfg_index,
  input  logic [lcdx_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  logic           class_valid;
  lcdx_pkg::job_t class_job;
  logic           q_full, q_not_empty, q_pop;
  lcdx_pkg::job_t q_job;
  logic           q_push;

  assign busy   = q_full;
  assign q_push = start && !q_full && class_valid;

  lcdx_front u_front (
    .in_item   (in_item),
    .job_valid (class_valid),
    .job       (class_job)
  );

  lcdx_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (class_job),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .pop_data  (q_job)
  );

  lcdx_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .job_valid  (q_not_empty),
    .job        (q_job),
    .job_pop    (q_pop),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

endmodule

`default_nettype wire

[sv/lcdx_front.sv]
// front end: classifies an accepted request into a queued job
// depends on lcdx_pkg
`default_nettype none

module lcdx_front (
  input  var lcdx_pkg::in_item_t in_item,
  output logic                   job_valid,
  output lcdx_pkg::job_t         job
);

  logic [7:0] addr_sum;

  assign addr_sum = {3'b000, in_item.column} + lcdx_pkg::row_base(in_item.line_index);

  always_comb begin
    job_valid   = 1'b1;
    job.is_init = 1'b0;
    job.rs      = 1'b0;
    job.cmd     = 8'h00;
    case (in_item.func)
      lcdx_pkg::FUNC_DATA: begin
        job.rs  = 1'b1;
        job.cmd = in_item.value;
      end
      lcdx_pkg::FUNC_CMD: begin
        job.cmd = in_item.value;
      end
      lcdx_pkg::FUNC_CURSOR: begin
        job.cmd = lcdx_pkg::LCD_SET_DDRAM | {1'b0, addr_sum[6:0]};
      end
      lcdx_pkg::FUNC_CLEAR: begin
        job.cmd = lcdx_pkg::LCD_CLEAR;
      end
      lcdx_pkg::FUNC_HOME: begin
        job.cmd = lcdx_pkg::LCD_HOME;
      end
      lcdx_pkg::FUNC_ENTRY: begin
        job.cmd = lcdx_pkg::LCD_ENTRY | {7'b0, in_item.shift_on};
      end
      lcdx_pkg::FUNC_INIT: begin
        job.is_init = 1'b1;
      end
      default: begin
        // unused code: nothing to send
        job_valid = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

[sv/lcdx_queue.sv]
// short job queue between front and back
// depends on lcdx_pkg
`default_nettype none

module lcdx_queue #(
  parameter int DEPTH = lcdx_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  lcdx_pkg::job_t push_data,
  input  logic           pop,
  output logic           full,
  output logic           not_empty,
  output lcdx_pkg::job_t pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  lcdx_pkg::job_t   slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full      = (count_r == CNT_FULL);
  assign not_empty = (count_r != '0);
  assign pop_data  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[sv/lcdx_back.sv]
// back end: expands one job into expander bytes, one per cycle
// depends on lcdx_pkg and the assertion macro header
`default_nettype none
`include "char_lcd_i2c_expander_sequencer_core_macros.svh"

module lcdx_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic                               cfg_index,
  input  logic [lcdx_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                               job_valid,
  input  lcdx_pkg::job_t                     job,
  output logic                               job_pop,
  output logic                               out_strobe,
  output lcdx_pkg::out_item_t                out_item
);

  typedef enum logic [1:0] {
    W_NONE,
    W_SETTLE,
    W_SETTLE_LONG,
    W_PAUSE
  } wsel_t;

  logic                backlight_r;
  logic [9:0]          settle_r;
  logic                active_r;
  lcdx_pkg::job_t      job_r;
  logic [4:0]          step_r;
  logic                out_strobe_r;
  lcdx_pkg::out_item_t out_item_r;

  logic                at_last;
  logic [4:0]          last_step;
  logic [4:0]          nib_step, cmd_step;
  logic [7:0]          cur_cmd;
  logic [1:0]          sub;
  logic [3:0]          nibble;
  logic                e_bit, rs_bit;
  wsel_t               wsel;
  lcdx_pkg::out_item_t out_item_nxt;

  assign last_step = job_r.is_init ? lcdx_pkg::LAST_STEP_INIT : lcdx_pkg::LAST_STEP_BYTE;
  assign at_last   = (step_r == last_step);
  assign job_pop   = job_valid && (!active_r || at_last);
  assign nib_step  = step_r - 5'd1;
  assign cmd_step  = step_r - lcdx_pkg::INIT_CMD_FIRST;

  always_comb begin
    cur_cmd = job_r.is_init ? lcdx_pkg::init_cmd(cmd_step[4:2]) : job_r.cmd;
    sub     = job_r.is_init ? cmd_step[1:0] : step_r[1:0];
    // byte run: high nibble first, each as e-high then e-low
    nibble  = sub[1] ? cur_cmd[3:0] : cur_cmd[7:4];
    e_bit   = !sub[0];
    rs_bit  = job_r.is_init ? 1'b0 : job_r.rs;
    wsel    = sub[0] ? W_SETTLE : W_NONE;
    if (job_r.is_init && step_r == '0) begin
      nibble = 4'h0;
      e_bit  = 1'b0;
      wsel   = W_PAUSE;
    end else if (job_r.is_init && step_r <= lcdx_pkg::INIT_NIB_LAST) begin
      // three 8-bit mode strobes, then the switch to 4-bit mode
      nibble = (nib_step[2:1] == 2'b11) ? 4'h2 : 4'h3;
      e_bit  = !nib_step[0];
      wsel   = nib_step[0] ? W_SETTLE_LONG : W_NONE;
    end
  end

  always_comb begin
    out_item_nxt.expander_byte = {nibble, backlight_r, e_bit, 1'b0, rs_bit};
    out_item_nxt.last          = at_last;
    case (wsel)
      W_NONE:        out_item_nxt.wait_us = '0;
      W_SETTLE:      out_item_nxt.wait_us = {3'b000, settle_r};
      W_SETTLE_LONG: out_item_nxt.wait_us = {3'b000, settle_r} + lcdx_pkg::POWER_UP_EXTRA;
      W_PAUSE:       out_item_nxt.wait_us = lcdx_pkg::INIT_PAUSE_US;
      default:       out_item_nxt.wait_us = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      backlight_r <= 1'b1;
      settle_r    <= lcdx_pkg::SETTLE_RESET_US;
    end else if (cfg_we) begin
      case (cfg_index)
        lcdx_pkg::CFG_BACKLIGHT: backlight_r <= cfg_wdata[0];
        lcdx_pkg::CFG_SETTLE:    settle_r    <= cfg_wdata;
        default:                 settle_r    <= settle_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r     <= 1'b0;
      step_r       <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= active_r;
      if (job_pop) begin
        active_r <= 1'b1;
        step_r   <= '0;
      end else if (active_r && at_last) begin
        active_r <= 1'b0;
      end else if (active_r) begin
        step_r <= step_r + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      job_r <= job;
    end
    out_item_r <= out_item_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

  `LCDX_ASSERT_NOW(a_no_early_pop, clk, rst_n, active_r && !at_last, !job_pop)
  `LCDX_ASSERT_NOW(a_step_bound, clk, rst_n, active_r, step_r <= last_step)
  `LCDX_ASSERT_NEXT(a_last_flag, clk, rst_n, active_r, out_strobe_r && out_item_r.last == $past(at_last))

endmodule

`default_nettype wire
